FILE: rtl/spmq_pkg.sv
// spmq_pkg: shared types and codes of the sorted priority message queue
// no dependencies; imported by the channel interfaces and every module

package spmq_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int STATUS_BITS = 2;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_PUT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_DELIVERED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] message_tag;
    logic [FIELD_BITS-1:0] priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [FIELD_BITS-1:0]  out_tag;
  } out_beat_t;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic put;
    logic get;
  } cell_op_t;

endpackage

FILE: rtl/spmq_if.sv
// spmq_in_if / spmq_out_if: valid-ready channels of the queue
// depends on spmq_pkg for the beat types

interface spmq_in_if;
  import spmq_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spmq_out_if;
  import spmq_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/spmq_cell.sv
// spmq_cell: one slot of the sorted row, holds a tag and a priority
// depends on spmq_pkg; neighbors are wired by spmq_cell_row

module spmq_cell #(
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spmq_pkg::cell_op_t       op,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic                     left_valid,
  input  logic                     left_gt,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic                     right_valid,
  input  logic [TAG_BITS-1:0]      right_tag,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic                     valid,
  output logic                     gt,
  output logic [TAG_BITS-1:0]      tag,
  output logic [PRIORITY_BITS-1:0] prio
);
  import spmq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [TAG_BITS-1:0]      tag_r, tag_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // new entry goes behind every entry with priority <= its own
  assign gt = !valid_r || (prio_r > new_prio);

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    if (op.put && gt) begin
      if (left_gt) begin
        valid_nxt = left_valid;
        tag_nxt   = left_tag;
        prio_nxt  = left_prio;
      end else begin
        valid_nxt = 1'b1;
        tag_nxt   = new_tag;
        prio_nxt  = new_prio;
      end
    end else if (op.get) begin
      valid_nxt = right_valid;
      tag_nxt   = right_tag;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign prio  = prio_r;

endmodule

FILE: rtl/spmq_cell_row.sv
// spmq_cell_row: chain of QUEUE_DEPTH cells, slot 0 is served next
// depends on spmq_pkg and spmq_cell

module spmq_cell_row #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spmq_pkg::cell_op_t       op,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  output logic [QUEUE_DEPTH-1:0]   valid_vec,
  output logic [TAG_BITS-1:0]      head_tag
);
  import spmq_pkg::*;

  logic [QUEUE_DEPTH-1:0]   gt_vec;
  logic [TAG_BITS-1:0]      tag_a  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_a [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     l_valid, l_gt, r_valid;
    logic [TAG_BITS-1:0]      l_tag, r_tag;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
      assign l_tag   = '0;
      assign l_prio  = '0;
    end else begin : g_mid_l
      assign l_valid = valid_vec[i-1];
      assign l_gt    = gt_vec[i-1];
      assign l_tag   = tag_a[i-1];
      assign l_prio  = prio_a[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_tag   = '0;
      assign r_prio  = '0;
    end else begin : g_mid_r
      assign r_valid = valid_vec[i+1];
      assign r_tag   = tag_a[i+1];
      assign r_prio  = prio_a[i+1];
    end

    spmq_cell #(
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .new_tag     (new_tag),
      .new_prio    (new_prio),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .left_tag    (l_tag),
      .left_prio   (l_prio),
      .right_valid (r_valid),
      .right_tag   (r_tag),
      .right_prio  (r_prio),
      .valid       (valid_vec[i]),
      .gt          (gt_vec[i]),
      .tag         (tag_a[i]),
      .prio        (prio_a[i])
    );
  end

  assign head_tag = tag_a[0];

endmodule

FILE: rtl/sorted_priority_message_queue.sv
// sorted_priority_message_queue: top level of the sorted message queue
// depends on spmq_pkg, spmq_if and spmq_cell_row
//
// usage
//   in_bus carries request beats: kind put (tag, priority) or kind get.
//   out_bus carries exactly one result beat per request: put accepted,
//   message delivered with its tag, queue empty, or queue full (dropped).
//   entries live in a row of QUEUE_DEPTH cells kept in service order; a put
//   lands behind every entry of equal or smaller priority and the cells
//   behind it move one place along, a get takes slot 0 and the row moves up.
//   every cell updates in the same cycle.
//   the result beat is valid the cycle after the request beat.
//   throughput: one request per cycle while out_bus drains; the output
//   register takes the next request in the same cycle its beat is taken.
//   when out_bus stalls, the result is held and in_bus.ready drops.
//   reset (rst_n low, synchronous) empties the queue and the output register.

module sorted_priority_message_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  spmq_in_if.sink  in_bus,
  spmq_out_if.source out_bus
);
  import spmq_pkg::*;

  logic [QUEUE_DEPTH-1:0]   valid_vec;
  logic [TAG_BITS-1:0]      head_tag;
  logic [TAG_BITS-1:0]      new_tag;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic                     accept, full, empty;
  cell_op_t                 op;
  out_beat_t                result;
  logic                     out_valid_r, out_valid_nxt;
  out_beat_t                out_data_r;

  assign new_tag  = TAG_BITS'(in_bus.data.message_tag);
  assign new_prio = PRIORITY_BITS'(in_bus.data.priority_req);

  assign full   = valid_vec[QUEUE_DEPTH-1];
  assign empty  = !valid_vec[0];
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept = in_bus.valid && in_bus.ready;

  assign op.put = accept && (in_bus.data.kind == KIND_PUT) && !full;
  assign op.get = accept && (in_bus.data.kind == KIND_GET) && !empty;

  spmq_cell_row #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TAG_BITS      (TAG_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .new_tag   (new_tag),
    .new_prio  (new_prio),
    .valid_vec (valid_vec),
    .head_tag  (head_tag)
  );

  always_comb begin
    result.out_tag = '0;
    if (in_bus.data.kind == KIND_PUT) begin
      result.status = full ? ST_FULL : ST_PUT_OK;
    end else if (empty) begin
      result.status = ST_EMPTY;
    end else begin
      result.status  = ST_DELIVERED;
      result.out_tag = FIELD_BITS'(head_tag);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  // occupied cells always form an unbroken run from slot 0
  a_valid_run : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("queue cells not contiguous");

  // a get on a non-empty queue delivers on the next beat
  a_get_delivers : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_bus.data.kind == KIND_GET) && !empty |=>
      out_valid_r && (out_data_r.status == ST_DELIVERED))
    else $error("get on non-empty queue not delivered");

  // a dropped put leaves the row occupancy unchanged and replies full
  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_bus.data.kind == KIND_PUT) && full |=>
      $stable(valid_vec) && (out_data_r.status == ST_FULL))
    else $error("put into full queue changed state");

endmodule

FILE: tb/sv/sorted_priority_message_queue_tb.sv
// sorted_priority_message_queue_tb: self-checking bench for the sorted message queue
// drives put/get request beats with random gaps and stalls and scores every reply beat
// depends on spmq_pkg, spmq_if and the sorted_priority_message_queue rtl

module sorted_priority_message_queue_tb;
  import spmq_pkg::*;

  localparam int QUEUE_DEPTH      = 16;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 357;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [FIELD_BITS-1:0] tag;
    logic [FIELD_BITS-1:0] prio;
  } slot_t;

  class spmq_scoreboard;
    slot_t     sorted_row[$];
    out_beat_t expected_replies[$];
    int        failures;
    int        requests;
    int        puts;
    int        drops;
    int        deliveries;
    int        empties;

    function new();
      failures   = 0;
      requests   = 0;
      puts       = 0;
      drops      = 0;
      deliveries = 0;
      empties    = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%s", msg);
      end
    endfunction

    function void note_request(in_beat_t req);
      out_beat_t reply;
      slot_t     slot;
      int        pos;
      requests++;
      reply.status  = ST_PUT_OK;
      reply.out_tag = '0;
      if (req.kind == KIND_PUT) begin
        if (sorted_row.size() >= QUEUE_DEPTH) begin
          reply.status = ST_FULL;
          drops++;
        end else begin
          slot.tag  = req.message_tag;
          slot.prio = req.priority_req;
          pos = 0;
          // new entry goes behind every entry of equal or smaller priority
          while (pos < sorted_row.size() && sorted_row[pos].prio <= slot.prio) begin
            pos++;
          end
          sorted_row.insert(pos, slot);
          puts++;
        end
      end else if (sorted_row.size() == 0) begin
        reply.status = ST_EMPTY;
        empties++;
      end else begin
        slot          = sorted_row.pop_front();
        reply.status  = ST_DELIVERED;
        reply.out_tag = slot.tag;
        deliveries++;
      end
      expected_replies.push_back(reply);
    endfunction

    function void check_reply(out_beat_t got);
      out_beat_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply beat with nothing pending: status %0d tag %h",
                         got.status, got.out_tag));
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        report($sformatf("status mismatch: expected %0d actual %0d (tag %h)",
                         want.status, got.status, got.out_tag));
      end else if (got.out_tag !== want.out_tag) begin
        report($sformatf("out_tag mismatch: expected %h actual %h (status %0d)",
                         want.out_tag, got.out_tag, got.status));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;

  spmq_scoreboard sb;

  spmq_in_if  in_bus ();
  spmq_out_if out_bus ();

  sorted_priority_message_queue #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TAG_BITS     (FIELD_BITS),
    .PRIORITY_BITS(FIELD_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sorted_priority_message_queue_tb: FAIL");
      $finish;
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_request(in_bus.data);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_reply(out_bus.data);
      end
    end
  end

  function automatic in_beat_t put_beat(input logic [FIELD_BITS-1:0] tag,
                                        input logic [FIELD_BITS-1:0] prio);
    in_beat_t req;
    req.kind         = KIND_PUT;
    req.message_tag  = tag;
    req.priority_req = prio;
    return req;
  endfunction

  function automatic in_beat_t get_beat();
    in_beat_t req;
    req.kind         = KIND_GET;
    req.message_tag  = FIELD_BITS'($urandom_range(0, 65535));
    req.priority_req = FIELD_BITS'($urandom_range(0, 65535));
    return req;
  endfunction

  task automatic send_request(input in_beat_t req);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= req;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_request(get_beat());
    send_request(put_beat(16'h0000, 16'hffff));
    send_request(put_beat(16'hffff, 16'h0000));
    send_request(put_beat(16'h1234, 16'd5));
    send_request(put_beat(16'h1235, 16'd5));
    send_request(put_beat(16'h1236, 16'd5));
    send_request(put_beat(16'haaaa, 16'hffff));
    send_request(put_beat(16'h5555, 16'h0000));
    for (int n = 0; n < 9; n++) begin
      send_request(put_beat(FIELD_BITS'($urandom_range(0, 65535)),
                            FIELD_BITS'($urandom_range(0, 7))));
    end
    // queue is full here, so this priority 0 put must be dropped
    send_request(put_beat(16'hffff, 16'h0000));
    for (int n = 0; n < 5; n++) begin
      send_request(get_beat());
    end
  endtask

  task automatic run_random(input int count);
    in_beat_t req;
    int       put_pct;
    int       burst_left;
    bit       narrow;
    put_pct    = 50;
    burst_left = 0;
    narrow     = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(12, 40);
        case ($urandom_range(0, 2))
          0: put_pct = 85;
          1: put_pct = 50;
          default: put_pct = 20;
        endcase
        narrow = 1'($urandom_range(0, 1));
      end
      burst_left--;
      req.kind        = ($urandom_range(0, 99) < put_pct) ? KIND_PUT : KIND_GET;
      req.message_tag = FIELD_BITS'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
        0: req.priority_req = '0;
        1: req.priority_req = '1;
        default: req.priority_req = narrow ? FIELD_BITS'($urandom_range(0, 3))
                                           : FIELD_BITS'($urandom_range(0, 65535));
      endcase
      send_request(req);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 47;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 47;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      run_random(RANDOM_PER_PHASE);
    end

    in_bus.valid <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected reply beats never arrived", sb.pending()));
    end

    $display("ran %0d requests under four gap/stall patterns: %0d puts stored, %0d dropped full",
             sb.requests, sb.puts, sb.drops);
    $display("replies: %0d deliveries, %0d gets on empty, %0d mismatches",
             sb.deliveries, sb.empties, sb.failures);
    if (sb.failures == 0) begin
      $display("sorted_priority_message_queue_tb: PASS");
    end else begin
      $display("sorted_priority_message_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
